// ----- sv/smpe_pkg.sv -----
// Package for the serial mouse protocol emulator.
// Holds the command codes, reply codes, decoded item kinds and the queue entry type.
// No dependencies.
package smpe_pkg;

  localparam int SMPE_FIFO_DEPTH = 2;

  // reply type bytes
  localparam logic [7:0] TYPE_DATA       = 8'h0b;
  localparam logic [7:0] TYPE_STATUS     = 8'h61;
  localparam logic [7:0] TYPE_RESET_ACK  = 8'hff;
  localparam logic [7:0] TYPE_CONFIGURED = 8'h20;

  // host command bytes
  localparam logic [7:0] CMD_RESET      = 8'h01;
  localparam logic [7:0] CMD_READ_CFG   = 8'h06;
  localparam logic [7:0] CMD_ENABLE     = 8'h08;
  localparam logic [7:0] CMD_DISABLE    = 8'h09;
  localparam logic [7:0] CMD_WRAP_ON    = 8'h0e;
  localparam logic [7:0] CMD_WRAP_OFF   = 8'h0f;
  localparam logic [7:0] CMD_EXP_SCALE  = 8'h78;
  localparam logic [7:0] CMD_LIN_SCALE  = 8'h6c;
  localparam logic [7:0] CMD_STATUS     = 8'h73;
  localparam logic [7:0] CMD_SET_RATE   = 8'h8a;
  localparam logic [7:0] CMD_SET_MODE   = 8'h8d;
  localparam logic [7:0] CMD_SET_RES    = 8'h89;

  localparam logic [7:0] MODE_REMOTE    = 8'h03;
  localparam logic [7:0] RESET_ACK_B1   = 8'h08;
  localparam logic [7:0] STATUS_ALWAYS  = 8'h04;
  localparam logic [7:0] DEFAULT_RES    = 8'd100;
  localparam logic [7:0] DEFAULT_RATE   = 8'd100;

  typedef enum logic [3:0] {
    K_MOTION,
    K_RESET,
    K_READ_CFG,
    K_ENABLE,
    K_DISABLE,
    K_CLEAR,
    K_EXP_SCALE,
    K_LIN_SCALE,
    K_STATUS,
    K_PEND_RATE,
    K_PEND_MODE,
    K_PEND_RES,
    K_PARAM
  } kind_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RATE = 2'd1,
    PEND_MODE = 2'd2,
    PEND_RES  = 2'd3
  } pend_t;

  // decoded item: motion items carry the finished packet bytes,
  // parameter bytes ride in b2
  typedef struct packed {
    kind_t      kind;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } entry_t;

endpackage

// ----- sv/serial_mouse_protocol_emulator.sv -----
// Serial mouse protocol emulator, device side: top level.
// Instantiates smpe_front, smpe_fifo and smpe_back; depends on smpe_pkg.
//
//   channel  | dir | tdata fields (low bit up)                 | tuser
//   s_*      | in  | cmd_byte, buttons, dx, dy (27 bits in 32)  | operation
//   m_*      | out | reply_type, reply_byte1..3 (32 bits)      | -
//
// One item per cycle sustained while the queue is not full. A reply goes valid on m_*
// after its item is accepted: the item is written into the decoded-item queue, then the
// back end loads the output register once the output slot is free.
// Reset (rst, synchronous) restores default settings and empties the queue and output.
// A stalled output holds the back end; the queue keeps taking items until full.
module serial_mouse_protocol_emulator #(
  parameter int FIFO_DEPTH = smpe_pkg::SMPE_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cmd_byte[7:0], buttons[10:8], dx[18:11], dy[26:19]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // reply_type, reply_byte1, reply_byte2, reply_byte3
);
  import smpe_pkg::*;

  entry_t decoded;
  entry_t q_entry;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  smpe_front u_front (
    .operation (s_tuser),
    .cmd_byte  (s_tdata[7:0]),
    .buttons   (s_tdata[10:8]),
    .dx        (s_tdata[18:11]),
    .dy        (s_tdata[26:19]),
    .entry     (decoded)
  );

  smpe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_entry (decoded),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .pop_entry  (q_entry)
  );

  assign s_tready = !q_full;

  smpe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- sv/smpe_front.sv -----
// Front end: classifies an incoming item and prebuilds the motion packet bytes.
// Depends on smpe_pkg.
module smpe_front (
  input  logic            operation,
  input  logic [7:0]      cmd_byte,
  input  logic [2:0]      buttons,
  input  logic [7:0]      dx,
  input  logic [7:0]      dy,
  output smpe_pkg::entry_t entry
);
  import smpe_pkg::*;

  logic [7:0] ny;
  logic [7:0] x_clamped;
  logic [7:0] y_clamped;
  logic [7:0] flags;

  assign ny        = 8'h00 - dy;
  assign x_clamped = (dx == 8'h80) ? 8'h81 : dx;
  assign y_clamped = (ny == 8'h80) ? 8'h81 : ny;
  assign flags     = {buttons[1], buttons[2], buttons[0], 2'b00, dx[7], ny[7], 1'b0};

  always_comb begin
    entry.b1 = flags;
    entry.b2 = x_clamped;
    entry.b3 = y_clamped;
    if (operation) begin
      entry.kind = K_MOTION;
    end else begin
      entry.b2 = cmd_byte;
      case (cmd_byte)
        CMD_RESET:     entry.kind = K_RESET;
        CMD_READ_CFG:  entry.kind = K_READ_CFG;
        CMD_ENABLE:    entry.kind = K_ENABLE;
        CMD_DISABLE:   entry.kind = K_DISABLE;
        CMD_WRAP_ON:   entry.kind = K_CLEAR;
        CMD_WRAP_OFF:  entry.kind = K_CLEAR;
        CMD_EXP_SCALE: entry.kind = K_EXP_SCALE;
        CMD_LIN_SCALE: entry.kind = K_LIN_SCALE;
        CMD_STATUS:    entry.kind = K_STATUS;
        CMD_SET_RATE:  entry.kind = K_PEND_RATE;
        CMD_SET_MODE:  entry.kind = K_PEND_MODE;
        CMD_SET_RES:   entry.kind = K_PEND_RES;
        default:       entry.kind = K_PARAM;
      endcase
    end
  end

endmodule

// ----- sv/smpe_fifo.sv -----
// Short queue of decoded items between front and back end.
// Depends on smpe_pkg. DEPTH must be at least 2.
module smpe_fifo #(
  parameter int DEPTH = smpe_pkg::SMPE_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  smpe_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output smpe_pkg::entry_t pop_entry
);
  import smpe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == FULL_CNT);
  assign valid     = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/smpe_back.sv -----
// Back end: holds the mouse settings, executes decoded items and registers replies.
// Depends on smpe_pkg.
module smpe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  smpe_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata
);
  import smpe_pkg::*;

  logic       enabled, enabled_next;
  logic       exp_scale, exp_scale_next;
  logic       remote, remote_next;
  logic [7:0] resolution, resolution_next;
  logic [7:0] rate, rate_next;
  pend_t      pending, pending_next;

  logic       has_reply;
  logic [7:0] r_type, r_b1, r_b2, r_b3;
  logic [7:0] status_flags;

  // output slot free or draining this cycle
  assign q_pop = q_valid && (!m_tvalid || m_tready);

  assign status_flags = STATUS_ALWAYS | {2'b00, !enabled, exp_scale, remote, 3'b000};

  always_comb begin
    enabled_next    = enabled;
    exp_scale_next  = exp_scale;
    remote_next     = remote;
    resolution_next = resolution;
    rate_next       = rate;
    pending_next    = PEND_NONE;
    has_reply       = 1'b0;
    r_type          = TYPE_DATA;
    r_b1            = q_entry.b1;
    r_b2            = q_entry.b2;
    r_b3            = q_entry.b3;
    case (q_entry.kind)
      K_MOTION: begin
        pending_next = pending;
        has_reply    = enabled;
      end
      K_RESET: begin
        enabled_next = 1'b1;
        has_reply    = 1'b1;
        r_type       = TYPE_RESET_ACK;
        r_b1         = RESET_ACK_B1;
        r_b2         = 8'h00;
        r_b3         = 8'h00;
      end
      K_READ_CFG: begin
        has_reply = 1'b1;
        r_type    = TYPE_CONFIGURED;
        r_b1      = 8'h00;
        r_b2      = 8'h00;
        r_b3      = 8'h00;
      end
      K_ENABLE:    enabled_next   = 1'b1;
      K_DISABLE:   enabled_next   = 1'b0;
      K_CLEAR:     pending_next   = PEND_NONE;
      K_EXP_SCALE: exp_scale_next = 1'b1;
      K_LIN_SCALE: exp_scale_next = 1'b0;
      K_STATUS: begin
        has_reply = 1'b1;
        r_type    = TYPE_STATUS;
        r_b1      = status_flags;
        r_b2      = resolution;
        r_b3      = rate;
      end
      K_PEND_RATE: pending_next = PEND_RATE;
      K_PEND_MODE: pending_next = PEND_MODE;
      K_PEND_RES:  pending_next = PEND_RES;
      K_PARAM: begin
        case (pending)
          PEND_RATE: rate_next       = q_entry.b2;
          PEND_MODE: remote_next     = (q_entry.b2 == MODE_REMOTE);
          PEND_RES:  resolution_next = q_entry.b2;
          default:   rate_next       = rate;
        endcase
      end
      default: pending_next = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b1;
      exp_scale  <= 1'b0;
      remote     <= 1'b0;
      resolution <= DEFAULT_RES;
      rate       <= DEFAULT_RATE;
      pending    <= PEND_NONE;
    end else if (q_pop) begin
      enabled    <= enabled_next;
      exp_scale  <= exp_scale_next;
      remote     <= remote_next;
      resolution <= resolution_next;
      rate       <= rate_next;
      pending    <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && has_reply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && has_reply) begin
      m_tdata <= {r_b3, r_b2, r_b1, r_type};
    end
  end

endmodule

// ----- sv/smpe_checker.sv -----
// Port-level checks for the serial mouse protocol emulator, bound to the top level.
// Depends on smpe_pkg.
module smpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import smpe_pkg::*;

  // reset empties the queue and the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("reset did not clear output and queue");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled reply changed");

  a_type_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == TYPE_DATA || m_tdata[7:0] == TYPE_STATUS ||
                  m_tdata[7:0] == TYPE_RESET_ACK || m_tdata[7:0] == TYPE_CONFIGURED))
    else $error("unknown reply type");

  // data packets never carry -128 on either axis
  a_data_clamped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] == TYPE_DATA) |->
      (m_tdata[23:16] != 8'h80 && m_tdata[31:24] != 8'h80 && m_tdata[8] == 1'b0))
    else $error("data packet not clamped");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] == TYPE_STATUS) |->
      (m_tdata[10] == 1'b1 && m_tdata[15:14] == 2'b00 && m_tdata[9:8] == 2'b00))
    else $error("malformed status reply");

endmodule

bind serial_mouse_protocol_emulator smpe_checker u_smpe_checker (.*);

// ----- tb/sv/serial_mouse_protocol_emulator_chk.sv -----
// Checker for the serial mouse protocol emulator: watches both streams, predicts replies.
// Keeps its own copy of the mouse settings; depends on smpe_pkg for codes and types.
module serial_mouse_protocol_emulator_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // cmd_byte[7:0], buttons[10:8], dx[18:11], dy[26:19]
  input  logic        s_tuser,   // operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // reply_type, reply_byte1, reply_byte2, reply_byte3
  output int          mismatches,
  output int          replies_due
);
  import smpe_pkg::*;

  localparam int MAX_REPORTS = 10;

  // mouse settings as the host has configured them
  logic       rpt_en;
  logic       exp_scale;
  logic       remote;
  logic [7:0] res_val;
  logic [7:0] rate_val;
  pend_t      pend;

  logic [31:0] reply_q[$];
  int          err_cnt = 0;
  logic        has_reply;
  logic [31:0] reply;
  logic [31:0] want;

  function automatic logic [7:0] clamp_min(input logic [7:0] v);
    return (v == 8'h80) ? 8'h81 : v;
  endfunction

  task automatic mouse_reply(input logic op, input logic [7:0] cmd, input logic [2:0] btn,
                             input logic [7:0] dx, input logic [7:0] dy,
                             output logic has, output logic [31:0] pkt);
    logic [7:0] ny;
    logic [7:0] flags;
    ny = 8'h00 - dy;
    has = 1'b0;
    pkt = '0;
    if (op) begin
      if (rpt_en) begin
        // right, middle, left, -, -, x sign, y sign, -
        flags = {btn[1], btn[2], btn[0], 2'b00, dx[7], ny[7], 1'b0};
        pkt = {clamp_min(ny), clamp_min(dx), flags, TYPE_DATA};
        has = 1'b1;
      end
    end else begin
      case (cmd)
        CMD_RESET: begin
          rpt_en = 1'b1;
          pend = PEND_NONE;
          pkt = {8'h00, 8'h00, RESET_ACK_B1, TYPE_RESET_ACK};
          has = 1'b1;
        end
        CMD_READ_CFG: begin
          pend = PEND_NONE;
          pkt = {8'h00, 8'h00, 8'h00, TYPE_CONFIGURED};
          has = 1'b1;
        end
        CMD_ENABLE: begin
          rpt_en = 1'b1;
          pend = PEND_NONE;
        end
        CMD_DISABLE: begin
          rpt_en = 1'b0;
          pend = PEND_NONE;
        end
        CMD_WRAP_ON, CMD_WRAP_OFF: pend = PEND_NONE;
        CMD_EXP_SCALE: begin
          exp_scale = 1'b1;
          pend = PEND_NONE;
        end
        CMD_LIN_SCALE: begin
          exp_scale = 1'b0;
          pend = PEND_NONE;
        end
        CMD_STATUS: begin
          flags = STATUS_ALWAYS | {2'b00, ~rpt_en, exp_scale, remote, 3'b000};
          pend = PEND_NONE;
          pkt = {rate_val, res_val, flags, TYPE_STATUS};
          has = 1'b1;
        end
        CMD_SET_RATE: pend = PEND_RATE;
        CMD_SET_MODE: pend = PEND_MODE;
        CMD_SET_RES:  pend = PEND_RES;
        default: begin
          // any other byte is a parameter, or dropped if nothing waits for one
          case (pend)
            PEND_RATE: rate_val = cmd;
            PEND_MODE: remote = (cmd == MODE_REMOTE);
            PEND_RES:  res_val = cmd;
            default: ;
          endcase
          pend = PEND_NONE;
        end
      endcase
    end
  endtask

  task automatic note_mismatch(input logic [31:0] exp_pkt, input logic [31:0] got_pkt,
                               input logic expected);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      if (expected)
        $display("reply mismatch: type %h/%h b1 %h/%h b2 %h/%h b3 %h/%h (exp/got)",
                 exp_pkt[7:0], got_pkt[7:0], exp_pkt[15:8], got_pkt[15:8],
                 exp_pkt[23:16], got_pkt[23:16], exp_pkt[31:24], got_pkt[31:24]);
      else
        $display("reply with nothing expected: %h %h %h %h",
                 got_pkt[7:0], got_pkt[15:8], got_pkt[23:16], got_pkt[31:24]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rpt_en    = 1'b1;
      exp_scale = 1'b0;
      remote    = 1'b0;
      res_val   = DEFAULT_RES;
      rate_val  = DEFAULT_RATE;
      pend      = PEND_NONE;
      reply_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          note_mismatch('0, m_tdata, 1'b0);
        end else begin
          want = reply_q.pop_front();
          if (want[7:0] !== m_tdata[7:0] || want[15:8] !== m_tdata[15:8] ||
              want[23:16] !== m_tdata[23:16] || want[31:24] !== m_tdata[31:24])
            note_mismatch(want, m_tdata, 1'b1);
        end
      end
      if (s_tvalid && s_tready) begin
        mouse_reply(s_tuser, s_tdata[7:0], s_tdata[10:8], s_tdata[18:11], s_tdata[26:19],
                    has_reply, reply);
        if (has_reply)
          reply_q.push_back(reply);
      end
    end
    mismatches  <= err_cnt;
    replies_due <= reply_q.size();
  end

endmodule

// ----- tb/sv/serial_mouse_protocol_emulator_tb.sv -----
// Testbench top for the serial mouse protocol emulator: clock, reset, stimulus, verdict.
// Instantiates serial_mouse_protocol_emulator and serial_mouse_protocol_emulator_chk.
module serial_mouse_protocol_emulator_tb;
  import smpe_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // cmd_byte[7:0], buttons[10:8], dx[18:11], dy[26:19]
  logic        s_tuser;   // operation
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // reply_type, reply_byte1, reply_byte2, reply_byte3

  int   mismatches;
  int   replies_due;
  int   cycles = 0;
  int   burst_left = 0;
  int   rnd_sent = 0;
  logic hold_req;
  bit   hold_done = 1'b0;

  serial_mouse_protocol_emulator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  serial_mouse_protocol_emulator_chk u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random ready pattern, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        case ($urandom_range(0, 7))
          0, 1: begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
          end
          2: begin
            m_tready <= 1'b1;
            repeat (100) @(posedge clk);
          end
          default: begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        endcase
      end
    end
  end

  // offer one item, wait for it to be taken, then maybe end the burst
  task automatic send_item(input logic op, input logic [7:0] cmd, input logic [2:0] btn,
                           input logic [7:0] dx, input logic [7:0] dy);
    int gap;
    s_tuser  <= op;
    s_tdata  <= {5'b00000, dy, dx, btn, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        gap = 0;
        burst_left = 60;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 5));
        burst_left = int'($urandom_range(1, 16));
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_host(input logic [7:0] b);
    send_item(1'b0, b, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic send_motion(input logic [2:0] btn, input logic [7:0] dx, input logic [7:0] dy);
    send_item(1'b1, 8'($urandom_range(0, 255)), btn, dx, dy);
  endtask

  task automatic wait_replies;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_command();
    case ($urandom_range(0, 11))
      0:  return CMD_RESET;
      1:  return CMD_READ_CFG;
      2:  return CMD_ENABLE;
      3:  return CMD_DISABLE;
      4:  return CMD_WRAP_ON;
      5:  return CMD_WRAP_OFF;
      6:  return CMD_EXP_SCALE;
      7:  return CMD_LIN_SCALE;
      8:  return CMD_STATUS;
      9:  return CMD_SET_RATE;
      10: return CMD_SET_MODE;
      default: return CMD_SET_RES;
    endcase
  endfunction

  initial begin
    int r;
    logic [7:0] setter;
    logic [7:0] param;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    hold_req <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, motion extremes, every command but enable, parameter corner cases
    send_host(CMD_STATUS);
    send_motion(3'd7, 8'h80, 8'h80);   // both axes at minimum, y wraps
    send_motion(3'd0, 8'h7f, 8'h7f);
    send_motion(3'd1, 8'hff, 8'h01);
    send_motion(3'd6, 8'h01, 8'h81);
    send_host(CMD_SET_RATE);
    send_host(8'd200);
    send_host(CMD_SET_RES);
    send_host(TYPE_DATA);              // data type byte from host is just a parameter
    send_host(CMD_SET_MODE);
    send_host(MODE_REMOTE);
    send_host(CMD_EXP_SCALE);
    send_host(CMD_DISABLE);
    send_motion(3'd3, 8'h05, 8'h05);   // suppressed while disabled
    send_host(CMD_STATUS);
    send_host(CMD_SET_MODE);
    send_host(CMD_STATUS);             // command code where a parameter is due
    send_host(8'hff);                  // nothing pending: dropped
    send_host(CMD_SET_MODE);
    send_host(8'h00);
    send_host(CMD_LIN_SCALE);
    send_host(CMD_WRAP_ON);
    send_host(CMD_WRAP_OFF);
    send_host(CMD_READ_CFG);
    send_host(CMD_RESET);

    hold_req <= 1'b1;
    while (rnd_sent < RANDOM_ITEMS) begin
      if (rnd_sent >= RANDOM_ITEMS / 2 && rnd_sent < RANDOM_ITEMS / 2 + 2)
        wait_replies();
      r = int'($urandom_range(0, 99));
      if (r < 45) begin
        send_motion(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        rnd_sent++;
      end else if (r < 65) begin
        case ($urandom_range(0, 2))
          0:       setter = CMD_SET_RATE;
          1:       setter = CMD_SET_MODE;
          default: setter = CMD_SET_RES;
        endcase
        case ($urandom_range(0, 7))
          0, 1:    param = MODE_REMOTE;
          2:       param = any_command();
          default: param = 8'($urandom_range(0, 255));
        endcase
        send_host(setter);
        send_host(param);
        rnd_sent += 2;
      end else if (r < 90) begin
        send_host(any_command());
        rnd_sent++;
      end else begin
        send_host(8'($urandom_range(0, 255)));
        rnd_sent++;
      end
    end

    wait_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
